// ===== sv/bfws_pkg.sv =====
// ----------------------------------------------------------------------------
// bfws_pkg
// Shared types, widths and codes of the best-fit worker selector.
// ----------------------------------------------------------------------------
package bfws_pkg;

    // parameter defaults
    localparam int WORKERS_DEF = 16;
    localparam int MODELS_DEF  = 8;
    localparam int LORAS_DEF   = 16;

    // fixed field widths
    localparam int KIND_W   = 2;
    localparam int SLOTP_W  = 4;
    localparam int LOAD_W   = 8;
    localparam int VRAM_W   = 20;
    localparam int BONUS_W  = 8;
    localparam int SCORE_W  = 10;
    localparam int MODELP_W = 3;
    localparam int LORAP_W  = 4;
    localparam int MASK_W   = 16;
    localparam int CFGI_W   = 2;
    localparam int CFGD_W   = 20;

    // configuration reset values
    localparam logic [BONUS_W-1:0] MODEL_BONUS_RST = 8'd100;
    localparam logic [BONUS_W-1:0] LORA_BONUS_RST  = 8'd40;
    localparam logic [BONUS_W-1:0] VRAM_BONUS_RST  = 8'd20;
    localparam logic [VRAM_W-1:0]  VRAM_NEED_RST   = 20'd2048;

    typedef enum logic [KIND_W-1:0] {
        KIND_REGISTER  = 2'd0,
        KIND_SET_MODEL = 2'd1,
        KIND_DISPATCH  = 2'd2,
        KIND_RELEASE   = 2'd3
    } t_kind;

    typedef enum logic [CFGI_W-1:0] {
        CFG_MODEL_BONUS = 2'd0,
        CFG_LORA_BONUS  = 2'd1,
        CFG_VRAM_BONUS  = 2'd2,
        CFG_VRAM_NEED   = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [BONUS_W-1:0] model_bonus;
        logic [BONUS_W-1:0] lora_bonus;
        logic [BONUS_W-1:0] vram_bonus;
        logic [VRAM_W-1:0]  vram_need;
    } t_cfg;

    typedef struct packed {
        logic              loaded;
        logic [MASK_W-1:0] mask;
    } t_entry;

    typedef struct packed {
        logic              healthy;
        logic [LOAD_W-1:0] load_cap;
        logic [VRAM_W-1:0] mem_total;
        logic [VRAM_W-1:0] mem_used;
    } t_slot_info;

    // write controls from the sequencer to the slot table
    typedef struct packed {
        logic              info_we;
        logic              load_we;
        logic              ent_we;
        t_slot_info        info;
        logic [LOAD_W-1:0] load;
        t_entry            ent;
    } t_tbl_ctl;

    // one slot as read back from the table
    typedef struct packed {
        logic              valid;
        t_slot_info        info;
        logic [LOAD_W-1:0] load;
        t_entry            ent;
    } t_slot_rd;

    // scored candidate
    typedef struct packed {
        logic               elig;
        logic [SCORE_W-1:0] score;
        logic [LOAD_W-1:0]  load;
    } t_cand;

endpackage

// ===== sv/bfws_table.sv =====
// ----------------------------------------------------------------------------
// bfws_table
// Worker slot table: valid flops, slot info / load memories and the
// per-slot model entry memory. One read address, registered read data.
// ----------------------------------------------------------------------------
module bfws_table #(
    parameter int WORKERS = bfws_pkg::WORKERS_DEF,
    parameter int MODELS  = bfws_pkg::MODELS_DEF,
    parameter int SLOT_W  = 4,
    parameter int MOD_W   = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [SLOT_W-1:0]  i_rd_slot,
    input  logic [MOD_W-1:0]   i_rd_model,
    input  logic [SLOT_W-1:0]  i_wr_slot,
    input  logic [MOD_W-1:0]   i_wr_model,
    input  bfws_pkg::t_tbl_ctl i_ctl,
    output bfws_pkg::t_slot_rd o_rd
);
    import bfws_pkg::*;

    localparam int ENTRIES = WORKERS * MODELS;
    localparam int ENT_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [WORKERS-1:0] r_valid;
    t_slot_info         r_info_mem [WORKERS];
    logic [LOAD_W-1:0]  r_load_mem [WORKERS];
    t_entry             r_ent_mem  [ENTRIES];
    t_slot_rd           r_rd;

    logic [ENT_W-1:0] ent_rd_addr;
    logic [ENT_W-1:0] ent_wr_addr;

    // entry address = slot * MODELS + model
    assign ent_rd_addr = ENT_W'(i_rd_slot) * ENT_W'(MODELS) + ENT_W'(i_rd_model);
    assign ent_wr_addr = ENT_W'(i_wr_slot) * ENT_W'(MODELS) + ENT_W'(i_wr_model);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.info_we) begin
            r_valid[i_wr_slot] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.info_we) begin
            r_info_mem[i_wr_slot] <= i_ctl.info;
        end
        if (i_ctl.load_we) begin
            r_load_mem[i_wr_slot] <= i_ctl.load;
        end
        if (i_ctl.ent_we) begin
            r_ent_mem[ent_wr_addr] <= i_ctl.ent;
        end
        r_rd.valid <= r_valid[i_rd_slot];
        r_rd.info  <= r_info_mem[i_rd_slot];
        r_rd.load  <= r_load_mem[i_rd_slot];
        r_rd.ent   <= r_ent_mem[ent_rd_addr];
    end

    assign o_rd = r_rd;

endmodule

// ===== sv/bfws_scorer.sv =====
// ----------------------------------------------------------------------------
// bfws_scorer
// Shared two-stage scorer: eligibility, VRAM check and headroom, then
// bonus sum. One slot enters per cycle.
// ----------------------------------------------------------------------------
module bfws_scorer #(
    parameter int SLOT_W = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_live,
    input  logic [SLOT_W-1:0]               i_idx,
    input  bfws_pkg::t_slot_rd              i_rd,
    input  bfws_pkg::t_cfg                  i_cfg,
    input  logic                            i_model_ok,
    input  logic [bfws_pkg::LORAP_W-1:0]    i_lora,
    input  logic                            i_lora_ok,
    output logic                            o_live,
    output logic                            o_busy,
    output logic [SLOT_W-1:0]               o_idx,
    output bfws_pkg::t_cand                 o_cand
);
    import bfws_pkg::*;

    // stage A
    logic              a_elig;
    logic [VRAM_W:0]   a_free;
    logic              r_a_live;
    logic              r_a_elig;
    logic              r_a_loaded;
    logic              r_a_lora;
    logic              r_a_vram;
    logic [LOAD_W-1:0] r_a_head;
    logic [LOAD_W-1:0] r_a_load;
    logic [SLOT_W-1:0] r_a_idx;

    // stage B
    logic [BONUS_W:0]  b_bonus;
    logic              r_b_live;
    logic [SLOT_W-1:0] r_b_idx;
    t_cand             r_b_cand;

    assign a_elig = i_rd.valid && i_rd.info.healthy && (i_rd.load < i_rd.info.load_cap);
    assign a_free = {1'b0, i_rd.info.mem_total} - {1'b0, i_rd.info.mem_used};

    always_comb begin
        if (r_a_loaded) begin
            b_bonus = {1'b0, i_cfg.model_bonus}
                    + (r_a_lora ? {1'b0, i_cfg.lora_bonus} : '0);
        end else if (r_a_vram) begin
            b_bonus = {1'b0, i_cfg.vram_bonus};
        end else begin
            b_bonus = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_live <= 1'b0;
            r_b_live <= 1'b0;
        end else begin
            r_a_live <= i_live;
            r_b_live <= r_a_live;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_elig   <= a_elig;
        r_a_loaded <= i_model_ok && i_rd.ent.loaded;
        r_a_lora   <= i_lora_ok && i_rd.ent.mask[i_lora];
        // used above total counts as no free VRAM
        r_a_vram   <= !a_free[VRAM_W] && (a_free[VRAM_W-1:0] >= i_cfg.vram_need);
        r_a_head   <= i_rd.info.load_cap - i_rd.load;
        r_a_load   <= i_rd.load;
        r_a_idx    <= i_idx;

        r_b_idx        <= r_a_idx;
        r_b_cand.elig  <= r_a_elig;
        r_b_cand.score <= SCORE_W'(b_bonus) + SCORE_W'(r_a_head);
        r_b_cand.load  <= r_a_load;
    end

    assign o_live = r_b_live;
    assign o_busy = r_a_live | r_b_live;
    assign o_idx  = r_b_idx;
    assign o_cand = r_b_cand;

endmodule

// ===== sv/best_fit_worker_selector.sv =====
// Steps from accept to result valid: dispatch reads the table once per slot
// through the shared scorer, drains it, updates the load and gives the result.
// Register writes the slot, then clears one model entry per cycle; set model
// and release read the slot, then give the result. A new word is taken while
// the last result waits. Reset (synchronous, active low) clears valid bits,
// config and control; slot data is only read behind a set valid bit.
// ----------------------------------------------------------------------------
// best_fit_worker_selector
// Worker slot table with best-score dispatch, load tracking and release.
// ----------------------------------------------------------------------------
module best_fit_worker_selector #(
    parameter int WORKERS = bfws_pkg::WORKERS_DEF,
    parameter int MODELS  = bfws_pkg::MODELS_DEF,
    parameter int LORAS   = bfws_pkg::LORAS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bfws_pkg::CFGI_W-1:0]     i_cfg_idx,
    input  logic [bfws_pkg::CFGD_W-1:0]     i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [bfws_pkg::KIND_W-1:0]     i_kind,
    input  logic [bfws_pkg::SLOTP_W-1:0]    i_slot,
    input  logic                            i_healthy,
    input  logic [bfws_pkg::LOAD_W-1:0]     i_load_cap,
    input  logic [bfws_pkg::LOAD_W-1:0]     i_start_load,
    input  logic [bfws_pkg::VRAM_W-1:0]     i_mem_total,
    input  logic [bfws_pkg::VRAM_W-1:0]     i_mem_used,
    input  logic [bfws_pkg::MODELP_W-1:0]   i_model_id,
    input  logic [bfws_pkg::LORAP_W-1:0]    i_lora_id,
    input  logic                            i_model_loaded,
    input  logic [bfws_pkg::MASK_W-1:0]     i_lora_mask,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_found,
    output logic [bfws_pkg::SLOTP_W-1:0]    o_chosen_slot,
    output logic [bfws_pkg::SCORE_W-1:0]    o_top_score,
    output logic [bfws_pkg::LOAD_W-1:0]     o_load_after
);
    import bfws_pkg::*;

    localparam int SLOT_W = (WORKERS > 1) ? $clog2(WORKERS) : 1;
    localparam int MOD_W  = (MODELS > 1) ? $clog2(MODELS) : 1;
    localparam int CNT_W  = $clog2(((WORKERS > MODELS) ? WORKERS : MODELS) + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_REG, ST_CLR, ST_RD, ST_RDW, ST_SCAN, ST_DRAIN, ST_UPD, ST_FIN
    } t_state;

    // configuration
    t_cfg r_cfg;

    // latched input word
    t_kind               r_kind;
    logic [SLOTP_W-1:0]  r_slot_in;
    logic [SLOT_W-1:0]   r_slot_idx;
    logic                r_in_range;
    t_slot_info          r_info_in;
    logic [LOAD_W-1:0]   r_start_load;
    logic                r_model_ok;
    logic [MOD_W-1:0]    r_model_idx;
    logic [LORAP_W-1:0]  r_lora;
    logic                r_lora_ok;
    t_entry              r_ent_in;

    // sequencer
    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_rd_live, n_rd_live;
    logic                r_have, n_have;
    logic [SCORE_W-1:0]  r_best, n_best;
    logic [SLOT_W-1:0]   r_best_idx, n_best_idx;
    logic [LOAD_W-1:0]   r_best_load, n_best_load;
    logic [LOAD_W-1:0]   r_res_load, n_res_load;
    logic                r_out_valid, n_out_valid;
    logic                r_out_found, n_out_found;
    logic [SLOTP_W-1:0]  r_out_slot, n_out_slot;
    logic [SCORE_W-1:0]  r_out_score, n_out_score;
    logic [LOAD_W-1:0]   r_out_load, n_out_load;

    // slot index that goes with the registered table read
    logic [SLOT_W-1:0]   r_best_idx_rd;

    logic                in_acc;
    logic [SLOT_W+SLOTP_W-1:0]   slot_ext;
    logic [MOD_W+MODELP_W-1:0]   model_ext;
    logic [SLOT_W+SLOTP_W-1:0]   best_ext;
    logic [SLOT_W-1:0]   rd_slot;
    logic [SLOT_W-1:0]   wr_slot;
    logic [MOD_W-1:0]    wr_model;
    t_tbl_ctl            tbl_ctl;
    t_slot_rd            tbl_rd;
    logic [LOAD_W-1:0]   cur_load;
    logic                sc_live;
    logic                sc_busy;
    logic [SLOT_W-1:0]   sc_idx;
    t_cand               sc_cand;
    logic [LOAD_W-1:0]   best_load_inc;

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == ST_IDLE);
    assign slot_ext   = {{SLOT_W{1'b0}}, i_slot};
    assign model_ext  = {{MOD_W{1'b0}}, i_model_id};
    assign best_ext   = {{SLOTP_W{1'b0}}, r_best_idx};
    assign best_load_inc = r_best_load + 1'b1;
    // a slot never registered has zero load
    assign cur_load   = tbl_rd.valid ? tbl_rd.load : '0;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.model_bonus <= MODEL_BONUS_RST;
            r_cfg.lora_bonus  <= LORA_BONUS_RST;
            r_cfg.vram_bonus  <= VRAM_BONUS_RST;
            r_cfg.vram_need   <= VRAM_NEED_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_MODEL_BONUS: r_cfg.model_bonus <= i_cfg_wdata[BONUS_W-1:0];
                CFG_LORA_BONUS:  r_cfg.lora_bonus  <= i_cfg_wdata[BONUS_W-1:0];
                CFG_VRAM_BONUS:  r_cfg.vram_bonus  <= i_cfg_wdata[BONUS_W-1:0];
                CFG_VRAM_NEED:   r_cfg.vram_need   <= i_cfg_wdata[VRAM_W-1:0];
                default: ;
            endcase
        end
    end

    // input word capture
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind              <= t_kind'(i_kind);
            r_slot_in           <= i_slot;
            r_slot_idx          <= slot_ext[SLOT_W-1:0];
            r_in_range          <= (32'(i_slot) < WORKERS);
            r_info_in.healthy   <= i_healthy;
            r_info_in.load_cap  <= i_load_cap;
            r_info_in.mem_total <= i_mem_total;
            r_info_in.mem_used  <= i_mem_used;
            r_start_load        <= i_start_load;
            r_model_ok          <= (32'(i_model_id) < MODELS);
            // out-of-range model reads entry 0, masked by r_model_ok
            r_model_idx         <= (32'(i_model_id) < MODELS) ? model_ext[MOD_W-1:0] : '0;
            r_lora              <= i_lora_id;
            r_lora_ok           <= (32'(i_lora_id) < LORAS);
            r_ent_in.loaded     <= i_model_loaded;
            r_ent_in.mask       <= i_lora_mask;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_rd_live   = 1'b0;
        n_have      = r_have;
        n_best      = r_best;
        n_best_idx  = r_best_idx;
        n_best_load = r_best_load;
        n_res_load  = r_res_load;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_found = r_out_found;
        n_out_slot  = r_out_slot;
        n_out_score = r_out_score;
        n_out_load  = r_out_load;
        rd_slot     = r_slot_idx;
        wr_slot     = r_slot_idx;
        wr_model    = r_model_idx;
        tbl_ctl         = '0;
        tbl_ctl.info    = r_info_in;
        tbl_ctl.load    = r_start_load;
        tbl_ctl.ent     = r_ent_in;

        // running best: first strictly higher score wins
        if (sc_live && sc_cand.elig && (!r_have || sc_cand.score > r_best)) begin
            n_have      = 1'b1;
            n_best      = sc_cand.score;
            n_best_idx  = sc_idx;
            n_best_load = sc_cand.load;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_cnt      = '0;
                    n_have     = 1'b0;
                    n_res_load = i_start_load;
                    unique case (t_kind'(i_kind))
                        KIND_REGISTER: begin
                            n_state = (32'(i_slot) < WORKERS) ? ST_REG : ST_FIN;
                        end
                        KIND_DISPATCH: begin
                            n_state = ST_SCAN;
                        end
                        default: begin
                            n_state = (32'(i_slot) < WORKERS) ? ST_RD : ST_FIN;
                        end
                    endcase
                end
            end
            ST_REG: begin
                tbl_ctl.info_we = 1'b1;
                tbl_ctl.load_we = 1'b1;
                n_cnt   = '0;
                n_state = ST_CLR;
            end
            ST_CLR: begin
                // wipe the slot's model entries, one per cycle
                tbl_ctl.ent_we = 1'b1;
                tbl_ctl.ent    = '0;
                wr_model       = r_cnt[MOD_W-1:0];
                if (r_cnt == CNT_W'(MODELS - 1)) begin
                    n_state = ST_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_RD: begin
                if (r_kind == KIND_SET_MODEL && r_model_ok) begin
                    tbl_ctl.ent_we = 1'b1;
                end
                n_state = ST_RDW;
            end
            ST_RDW: begin
                n_res_load = cur_load;
                if (r_kind == KIND_RELEASE && cur_load != '0) begin
                    tbl_ctl.load_we = 1'b1;
                    tbl_ctl.load    = cur_load - 1'b1;
                    n_res_load      = cur_load - 1'b1;
                end
                n_state = ST_FIN;
            end
            ST_SCAN: begin
                rd_slot   = r_cnt[SLOT_W-1:0];
                n_rd_live = 1'b1;
                if (r_cnt == CNT_W'(WORKERS - 1)) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (!r_rd_live && !sc_busy) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                wr_slot         = r_best_idx;
                tbl_ctl.load_we = r_have;
                tbl_ctl.load    = best_load_inc;
                n_state         = ST_FIN;
            end
            ST_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    if (r_kind == KIND_DISPATCH) begin
                        n_out_found = r_have;
                        n_out_slot  = r_have ? best_ext[SLOTP_W-1:0] : '0;
                        n_out_score = r_have ? r_best : '0;
                        n_out_load  = r_have ? best_load_inc : '0;
                    end else begin
                        n_out_found = 1'b0;
                        n_out_slot  = r_slot_in;
                        n_out_score = '0;
                        n_out_load  = r_in_range ? r_res_load : '0;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_rd_live   <= 1'b0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_rd_live   <= n_rd_live;
            r_have      <= n_have;
            r_out_valid <= n_out_valid;
        end
        r_best      <= n_best;
        r_best_idx  <= n_best_idx;
        r_best_load <= n_best_load;
        r_res_load  <= n_res_load;
        r_out_found <= n_out_found;
        r_out_slot  <= n_out_slot;
        r_out_score <= n_out_score;
        r_out_load  <= n_out_load;
    end

    bfws_table #(
        .WORKERS (WORKERS),
        .MODELS  (MODELS),
        .SLOT_W  (SLOT_W),
        .MOD_W   (MOD_W)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_slot  (rd_slot),
        .i_rd_model (r_model_idx),
        .i_wr_slot  (wr_slot),
        .i_wr_model (wr_model),
        .i_ctl      (tbl_ctl),
        .o_rd       (tbl_rd)
    );

    bfws_scorer #(
        .SLOT_W (SLOT_W)
    ) u_scorer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_live     (r_rd_live),
        .i_idx      (r_best_idx_rd),
        .i_rd       (tbl_rd),
        .i_cfg      (r_cfg),
        .i_model_ok (r_model_ok),
        .i_lora     (r_lora),
        .i_lora_ok  (r_lora_ok),
        .o_live     (sc_live),
        .o_busy     (sc_busy),
        .o_idx      (sc_idx),
        .o_cand     (sc_cand)
    );

    always_ff @(posedge i_clk) begin
        r_best_idx_rd <= rd_slot;
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_out_found;
    assign o_chosen_slot = r_out_slot;
    assign o_top_score   = r_out_score;
    assign o_load_after  = r_out_load;

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != ST_IDLE))
        else $error("input word accepted but sequencer stayed idle");

    a_scorer_quiet_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !sc_busy)
        else $error("scorer still active while idle");

    a_found_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> (o_load_after != '0))
        else $error("dispatch winner reports zero load");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_top_score == '0))
        else $error("nonzero score without a winner");
`endif

endmodule
